### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/rot_pkg.sv
package rot_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int TRIG_FRAC_BITS = 14;

    localparam int X_W    = 10;
    localparam int Y_W    = 10;
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int TRIG_W = 16;

    localparam int AX_W   = $clog2(MAX_WIDTH);
    localparam int AY_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = AX_W + AY_W;

    localparam int D_W    = DIM_W + 1;
    localparam int PROD_W = D_W + TRIG_W;
    localparam int OFS_W  = D_W + TRIG_FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
    localparam int SRC_W  = SUM_W - TRIG_FRAC_BITS - 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COS_VALUE    = 2'd2;
    localparam logic [1:0] REG_SIN_VALUE    = 2'd3;

    localparam logic [DIM_W-1:0]         RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]         RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic signed [TRIG_W-1:0] RST_COS_VALUE    = 16'sd15296;
    localparam logic signed [TRIG_W-1:0] RST_SIN_VALUE    = 16'sd5872;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [DIM_W-1:0]         image_width;
        logic [DIM_W-1:0]         image_height;
        logic signed [TRIG_W-1:0] cos_value;
        logic signed [TRIG_W-1:0] sin_value;
    } rot_cfg_t;

    typedef struct packed
    {
        cmd_t              kind;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
        logic              outside;
    } rot_op_t;

endpackage

### hw/rtl/image_rotate_nearest_neighbour.sv
// Channel   Direction  Transfer contents
// s_axis    in         tuser: cmd; tdata: pos_x, pos_y, pixel_in
// m_axis    out        tuser: outside; tdata: pixel_out
// apb       in/out     image_width, image_height, cos_value, sin_value
//
// One item is taken per cycle while s_axis_tready is high; a fetch result leaves after
// passing through the three front stages, the queue, the store read and the output
// register.
// Loads produce no result and write the frame store in the back part.
// A stalled m_axis fills the four-entry queue, after which s_axis drops tready.
// Reset clears control state only; the frame store holds garbage until loaded.
module image_rotate_nearest_neighbour
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // pos_x, pos_y, pixel_in
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // pixel_out
    output logic                          m_axis_tuser,  // outside
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rot_pkg::PADDR_W-1:0]   paddr,
    input  logic [rot_pkg::PDATA_W-1:0]   pwdata,
    output logic [rot_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    rot_pkg::rot_cfg_t  cfg_reg;
    logic               cfg_we;
    logic [1:0]         reg_sel;
    logic               push;
    logic               q_full;
    logic               pop;
    logic               head_valid;
    rot_pkg::rot_op_t   push_op;
    rot_pkg::rot_op_t   head_op;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= rot_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= rot_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.cos_value    <= rot_pkg::RST_COS_VALUE;
            cfg_reg.sin_value    <= rot_pkg::RST_SIN_VALUE;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                rot_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= pwdata[rot_pkg::DIM_W-1:0];
                rot_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= pwdata[rot_pkg::DIM_W-1:0];
                rot_pkg::REG_COS_VALUE:
                    cfg_reg.cos_value <= $signed(pwdata[rot_pkg::TRIG_W-1:0]);
                rot_pkg::REG_SIN_VALUE:
                    cfg_reg.sin_value <= $signed(pwdata[rot_pkg::TRIG_W-1:0]);
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            rot_pkg::REG_IMAGE_WIDTH:  prdata = rot_pkg::PDATA_W'(cfg_reg.image_width);
            rot_pkg::REG_IMAGE_HEIGHT: prdata = rot_pkg::PDATA_W'(cfg_reg.image_height);
            rot_pkg::REG_COS_VALUE:    prdata = rot_pkg::PDATA_W'(cfg_reg.cos_value);
            rot_pkg::REG_SIN_VALUE:    prdata = rot_pkg::PDATA_W'(cfg_reg.sin_value);
            default:                   prdata = '0;
        endcase
    end

    rot_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (rot_pkg::cmd_t'(s_axis_tuser)),
        .in_x     (s_axis_tdata[9:0]),
        .in_y     (s_axis_tdata[19:10]),
        .in_pix   (s_axis_tdata[27:20]),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    rot_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    rot_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (head_valid),
        .q_op        (head_op),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_pixel   (m_axis_tdata),
        .out_outside (m_axis_tuser)
    );

endmodule

### hw/rtl/rot_front.sv
module rot_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rot_pkg::rot_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rot_pkg::cmd_t               in_cmd,
    input  logic [rot_pkg::X_W-1:0]     in_x,
    input  logic [rot_pkg::Y_W-1:0]     in_y,
    input  logic [rot_pkg::PIX_W-1:0]   in_pix,
    input  logic                        q_full,
    output logic                        push,
    output rot_pkg::rot_op_t            push_op
);

    localparam logic signed [rot_pkg::SUM_W-1:0] TRUNC_BIAS =
        rot_pkg::SUM_W'((1 << (rot_pkg::TRIG_FRAC_BITS + 1)) - 1);

    // Division by 2^(F+1) rounding toward zero.
    function automatic logic signed [rot_pkg::SRC_W-1:0] trunc_src
    (
        input logic signed [rot_pkg::SUM_W-1:0] n
    );
        logic signed [rot_pkg::SUM_W-1:0] t;
        t = n + (n[rot_pkg::SUM_W-1] ? TRUNC_BIAS : '0);
        return t[rot_pkg::SUM_W-1:rot_pkg::TRIG_FRAC_BITS+1];
    endfunction

    function automatic logic in_range
    (
        input logic signed [rot_pkg::SRC_W-1:0] s,
        input logic [rot_pkg::DIM_W-1:0]        lim,
        input int                               max_dim
    );
        logic [31:0] mag;
        mag = 32'(s[rot_pkg::SRC_W-2:0]);
        return !s[rot_pkg::SRC_W-1] && (mag < 32'(lim)) && (mag < 32'(max_dim));
    endfunction

    logic                                a_valid_reg;
    rot_pkg::cmd_t                       a_cmd_reg;
    logic [rot_pkg::X_W-1:0]             a_x_reg;
    logic [rot_pkg::Y_W-1:0]             a_y_reg;
    logic [rot_pkg::PIX_W-1:0]           a_pix_reg;

    logic                                b_valid_reg;
    rot_pkg::cmd_t                       b_cmd_reg;
    logic                                b_keep_reg;
    logic [rot_pkg::ADDR_W-1:0]          b_addr_reg;
    logic [rot_pkg::PIX_W-1:0]           b_pix_reg;
    logic signed [rot_pkg::PROD_W-1:0]   b_xc_reg;
    logic signed [rot_pkg::PROD_W-1:0]   b_ys_reg;
    logic signed [rot_pkg::PROD_W-1:0]   b_xs_reg;
    logic signed [rot_pkg::PROD_W-1:0]   b_yc_reg;

    logic                                c_valid_reg;
    rot_pkg::cmd_t                       c_cmd_reg;
    logic                                c_keep_reg;
    logic [rot_pkg::ADDR_W-1:0]          c_addr_reg;
    logic [rot_pkg::PIX_W-1:0]           c_pix_reg;
    logic signed [rot_pkg::SUM_W-1:0]    c_nx_reg;
    logic signed [rot_pkg::SUM_W-1:0]    c_ny_reg;

    logic                                adv;
    logic signed [rot_pkg::D_W-1:0]      dx;
    logic signed [rot_pkg::D_W-1:0]      dy;
    logic                                load_ok;
    logic [rot_pkg::ADDR_W-1:0]          load_addr;
    logic [rot_pkg::D_W-1:0]             wp1;
    logic [rot_pkg::D_W-1:0]             hp1;
    logic signed [rot_pkg::SUM_W-1:0]    ofs_x;
    logic signed [rot_pkg::SUM_W-1:0]    ofs_y;
    logic signed [rot_pkg::SUM_W-1:0]    nx_next;
    logic signed [rot_pkg::SUM_W-1:0]    ny_next;
    logic signed [rot_pkg::SRC_W-1:0]    sx;
    logic signed [rot_pkg::SRC_W-1:0]    sy;
    logic                                src_in_frame;
    logic [rot_pkg::ADDR_W-1:0]          fetch_addr;

    // The whole front advances together; it only waits when the queue is full.
    assign adv      = !c_valid_reg || !q_full;
    assign in_ready = adv;

    assign dx = $signed(rot_pkg::D_W'({a_x_reg, 1'b0})) - $signed(rot_pkg::D_W'(cfg.image_width));
    assign dy = $signed(rot_pkg::D_W'({a_y_reg, 1'b0})) - $signed(rot_pkg::D_W'(cfg.image_height));

    assign load_ok   = (32'(a_x_reg) < 32'(rot_pkg::MAX_WIDTH)) &&
                       (32'(a_y_reg) < 32'(rot_pkg::MAX_HEIGHT));
    assign load_addr = rot_pkg::ADDR_W'(32'(a_y_reg) * 32'(rot_pkg::MAX_WIDTH) + 32'(a_x_reg));

    assign wp1   = rot_pkg::D_W'(cfg.image_width) + rot_pkg::D_W'(1);
    assign hp1   = rot_pkg::D_W'(cfg.image_height) + rot_pkg::D_W'(1);
    assign ofs_x = $signed(rot_pkg::SUM_W'(wp1) << rot_pkg::TRIG_FRAC_BITS);
    assign ofs_y = $signed(rot_pkg::SUM_W'(hp1) << rot_pkg::TRIG_FRAC_BITS);

    assign nx_next = rot_pkg::SUM_W'(b_xc_reg) - rot_pkg::SUM_W'(b_ys_reg) + ofs_x;
    assign ny_next = rot_pkg::SUM_W'(b_xs_reg) + rot_pkg::SUM_W'(b_yc_reg) + ofs_y;

    assign sx     = trunc_src(c_nx_reg);
    assign sy     = trunc_src(c_ny_reg);
    assign src_in_frame = in_range(sx, cfg.image_width, rot_pkg::MAX_WIDTH) &&
                          in_range(sy, cfg.image_height, rot_pkg::MAX_HEIGHT);
    assign fetch_addr = rot_pkg::ADDR_W'(32'(sy[rot_pkg::SRC_W-2:0]) * 32'(rot_pkg::MAX_WIDTH)
                                         + 32'(sx[rot_pkg::SRC_W-2:0]));

    assign push = c_valid_reg && !q_full && c_keep_reg;

    always_comb
    begin
        push_op.kind    = c_cmd_reg;
        push_op.pixel   = c_pix_reg;
        push_op.addr    = (c_cmd_reg == rot_pkg::CMD_FETCH) ? fetch_addr : c_addr_reg;
        push_op.outside = !src_in_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg  <= in_cmd;
            a_x_reg    <= in_x;
            a_y_reg    <= in_y;
            a_pix_reg  <= in_pix;

            b_cmd_reg  <= a_cmd_reg;
            b_keep_reg <= (a_cmd_reg == rot_pkg::CMD_FETCH) || load_ok;
            b_addr_reg <= load_addr;
            b_pix_reg  <= a_pix_reg;
            b_xc_reg   <= rot_pkg::PROD_W'(dx) * rot_pkg::PROD_W'(cfg.cos_value);
            b_ys_reg   <= rot_pkg::PROD_W'(dy) * rot_pkg::PROD_W'(cfg.sin_value);
            b_xs_reg   <= rot_pkg::PROD_W'(dx) * rot_pkg::PROD_W'(cfg.sin_value);
            b_yc_reg   <= rot_pkg::PROD_W'(dy) * rot_pkg::PROD_W'(cfg.cos_value);

            c_cmd_reg  <= b_cmd_reg;
            c_keep_reg <= b_keep_reg;
            c_addr_reg <= b_addr_reg;
            c_pix_reg  <= b_pix_reg;
            c_nx_reg   <= nx_next;
            c_ny_reg   <= ny_next;
        end
    end

endmodule

### hw/rtl/rot_queue.sv
`include "assert_macros.svh"

module rot_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rot_pkg::rot_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output rot_pkg::rot_op_t head_op
);

    rot_pkg::rot_op_t                 slot_reg [rot_pkg::Q_DEPTH];
    logic [rot_pkg::Q_IDX_W-1:0]      wr_ptr_reg;
    logic [rot_pkg::Q_IDX_W-1:0]      rd_ptr_reg;
    logic [rot_pkg::Q_IDX_W:0]        count_reg;
    logic [rot_pkg::Q_IDX_W:0]        count_next;

    assign full       = (count_reg == (rot_pkg::Q_IDX_W + 1)'(rot_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (rot_pkg::Q_IDX_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (rot_pkg::Q_IDX_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rot_pkg::Q_IDX_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rot_pkg::Q_IDX_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    `ASSERT_IMPLIES(a_q_no_overflow, push, !full, "queue written while full")
    `ASSERT_IMPLIES(a_q_no_underflow, pop, head_valid, "queue read while empty")
    `ASSERT_NEXT(a_q_fill, push && !pop, head_valid, "queue empty after a lone write")

endmodule

### hw/rtl/rot_back.sv
module rot_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  rot_pkg::rot_op_t          q_op,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [rot_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_outside
);

    logic [rot_pkg::PIX_W-1:0] frame_mem [1 << rot_pkg::ADDR_W];

    logic                      rd_valid_reg;
    logic                      rd_outside_reg;
    logic [rot_pkg::PIX_W-1:0] rd_data_reg;
    logic                      o_valid_reg;
    logic [rot_pkg::PIX_W-1:0] o_pixel_reg;
    logic                      o_outside_reg;
    logic                      o_free;
    logic                      rd_adv;
    logic                      is_fetch;

    assign o_free   = !o_valid_reg || out_ready;
    assign rd_adv   = !rd_valid_reg || o_free;
    assign q_pop    = q_valid && rd_adv;
    assign is_fetch = (q_op.kind == rot_pkg::CMD_FETCH);

    assign out_valid   = o_valid_reg;
    assign out_pixel   = o_pixel_reg;
    assign out_outside = o_outside_reg;

    // One store access per cycle: a load writes, a fetch reads.
    always_ff @(posedge clk)
    begin
        if (q_pop && !is_fetch)
        begin
            frame_mem[q_op.addr] <= q_op.pixel;
        end
        if (q_pop && is_fetch)
        begin
            rd_data_reg    <= frame_mem[q_op.addr];
            rd_outside_reg <= q_op.outside;
        end
        if (o_free && rd_valid_reg)
        begin
            o_pixel_reg   <= rd_outside_reg ? '0 : rd_data_reg;
            o_outside_reg <= rd_outside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_adv)
            begin
                rd_valid_reg <= q_pop && is_fetch;
            end
            if (o_free)
            begin
                o_valid_reg <= rd_valid_reg;
            end
        end
    end

endmodule
